// File: rtl/core/rc4_stream_cipher_nonzero_unit_assert.svh
// assertion macros shared by the cipher unit
`ifndef RC4_STREAM_CIPHER_NONZERO_UNIT_ASSERT_SVH
`define RC4_STREAM_CIPHER_NONZERO_UNIT_ASSERT_SVH

// same-cycle implication
`define RC4SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RC4SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rc4sc_pkg.sv
package rc4sc_pkg;

	localparam int KEY_BYTES  = 16;
	localparam int KEY_WORDS  = 4;
	localparam int KEY_W      = 64;
	localparam int KEY_SEL_W  = 5;
	localparam int KIDX_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = 8;
	localparam int STEP_W     = 4;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_WORD_0 = 2'd0;
	localparam logic [1:0] CFG_KEY_WORD_1 = 2'd1;
	localparam logic [1:0] CFG_KEY_WORD_2 = 2'd2;
	localparam logic [1:0] CFG_KEY_WORD_3 = 2'd3;

	// program steps
	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_P0    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_P1    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_P2    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_P3    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_P4    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_P5    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_OUT   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_INIT  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_K0    = 4'd9;
	localparam logic [STEP_W-1:0] STEP_K1    = 4'd10;
	localparam logic [STEP_W-1:0] STEP_K2    = 4'd11;
	localparam logic [STEP_W-1:0] STEP_K3    = 4'd12;
	localparam logic [STEP_W-1:0] STEP_K4    = 4'd13;
	localparam logic [STEP_W-1:0] STEP_SEND  = 4'd14;

	// read address select
	localparam logic [2:0] RD_NONE   = 3'd0;
	localparam logic [2:0] RD_I_NEXT = 3'd1;
	localparam logic [2:0] RD_J      = 3'd2;
	localparam logic [2:0] RD_AB     = 3'd3;
	localparam logic [2:0] RD_N      = 3'd4;

	// write select
	localparam logic [2:0] WR_NONE   = 3'd0;
	localparam logic [2:0] WR_N_IDX  = 3'd1;
	localparam logic [2:0] WR_N_RD   = 3'd2;
	localparam logic [2:0] WR_I_RD   = 3'd3;
	localparam logic [2:0] WR_J_A    = 3'd4;

	// jump conditions
	localparam logic [2:0] COND_NEXT   = 3'd0;
	localparam logic [2:0] COND_GOTO   = 3'd1;
	localparam logic [2:0] COND_ACCEPT = 3'd2;
	localparam logic [2:0] COND_OUT    = 3'd3;
	localparam logic [2:0] COND_LOOP_N = 3'd4;

	typedef struct packed {
		logic              in_rdy;
		logic              out_ld;
		logic [2:0]        rd_sel;
		logic [2:0]        wr_sel;
		logic              a_ld;
		logic              key_add;
		logic              b_ld;
		logic              i_inc;
		logic              n_inc;
		logic              k_inc;
		logic              sch_init;
		logic              sch_end;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic accept;
		logic need_sched;
		logic out_free;
		logic n_last;
	} seq_flags_t;

	// microcode rom
	function automatic ctl_word_t ucode(input logic [STEP_W-1:0] s);
		ctl_word_t w;
		begin
			w = '0;
			case (s)
				STEP_IDLE: begin
					w.in_rdy = 1'b1;
					w.cond   = COND_ACCEPT;
					w.target = STEP_INIT;
				end
				STEP_P0: begin
					w.rd_sel = RD_I_NEXT;
					w.i_inc  = 1'b1;
				end
				STEP_P1: begin
					w.a_ld = 1'b1;
				end
				STEP_P2: begin
					w.rd_sel = RD_J;
				end
				STEP_P3: begin
					w.b_ld   = 1'b1;
					w.wr_sel = WR_I_RD;
				end
				STEP_P4: begin
					w.wr_sel = WR_J_A;
				end
				STEP_P5: begin
					w.rd_sel = RD_AB;
				end
				STEP_OUT: begin
					w.out_ld = 1'b1;
					w.cond   = COND_OUT;
					w.target = STEP_IDLE;
				end
				STEP_INIT: begin
					w.wr_sel   = WR_N_IDX;
					w.n_inc    = 1'b1;
					w.sch_init = 1'b1;
					w.cond     = COND_LOOP_N;
					w.target   = STEP_INIT;
				end
				STEP_K0: begin
					w.rd_sel = RD_N;
				end
				STEP_K1: begin
					w.a_ld    = 1'b1;
					w.key_add = 1'b1;
				end
				STEP_K2: begin
					w.rd_sel = RD_J;
				end
				STEP_K3: begin
					w.wr_sel = WR_N_RD;
				end
				STEP_K4: begin
					w.wr_sel = WR_J_A;
					w.n_inc  = 1'b1;
					w.k_inc  = 1'b1;
					w.cond   = COND_LOOP_N;
					w.target = STEP_K0;
				end
				STEP_SEND: begin
					w.sch_end = 1'b1;
					w.cond    = COND_GOTO;
					w.target  = STEP_P0;
				end
				default: begin
					w.cond   = COND_GOTO;
					w.target = STEP_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

// File: rtl/core/rc4sc_seq.sv
module rc4sc_seq
	import rc4sc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  seq_flags_t        flags,
	output ctl_word_t         ctl,
	output logic [STEP_W-1:0] step
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;

	assign ctl  = ucode(step_q);
	assign step = step_q;

	always_comb begin
		case (ctl.cond)
			COND_NEXT:   step_nxt = step_q + 1'b1;
			COND_GOTO:   step_nxt = ctl.target;
			COND_ACCEPT: begin
				if (!flags.accept)
					step_nxt = step_q;
				else if (flags.need_sched)
					step_nxt = ctl.target;
				else
					step_nxt = step_q + 1'b1;
			end
			COND_OUT:    step_nxt = flags.out_free ? ctl.target : step_q;
			COND_LOOP_N: step_nxt = flags.n_last ? step_q + 1'b1 : ctl.target;
			default:     step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_nxt;
	end

endmodule

// File: rtl/core/rc4_stream_cipher_nonzero_unit.sv
// channel  | handshake                    | payload
// ---------+------------------------------+-------------------------------
// data     | data_valid / data_stall      | data_byte, last_byte
// result   | result_valid / result_stall  | out_byte, out_last
// config   | cfg_we (no stall)            | cfg_index, cfg_data
//
// a byte runs through steps P0 to P5 and OUT before the next item can be taken; the
// permutation memory has one read and one write port: three dependent reads, two writes
// the first byte of a message first runs the key schedule: the INIT step fills all
// 256 entries, steps K0 to K4 swap once per entry, and one hand-off step, SEND, follows
// reset clears the sequencer, indices and key words; the schedule rebuilds the table
// a stalled result holds the output register while the next item runs to its output step
`include "rc4_stream_cipher_nonzero_unit_assert.svh"

module rc4_stream_cipher_nonzero_unit
	import rc4sc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// data channel
	input  logic         data_valid,
	output logic         data_stall,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	// result channel
	output logic         result_valid,
	input  logic         result_stall,
	output logic [7:0]   out_byte,
	output logic         out_last,
	// configuration
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [KEY_W-1:0] cfg_data
);

	ctl_word_t         ctl;
	seq_flags_t        flags;
	logic [STEP_W-1:0] step;

	// key storage
	logic [KEY_W-1:0]  key_q [KEY_WORDS];
	logic [KEY_WORDS*KEY_W-1:0] key_flat;
	logic [KEY_SEL_W-1:0] key_sel;
	logic [7:0]        key_byte;

	// datapath state
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  n_q;
	logic [KIDX_W-1:0] kidx_q;
	logic              need_q;
	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic [7:0]        data_q;
	logic              last_q;

	// output register
	logic              result_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	// permutation memory
	logic [7:0]        perm_mem [TABLE_SIZE];
	logic [7:0]        rd_q;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [7:0]        mem_wdata;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [7:0]        ks_xor;

	rc4sc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.step   (step)
	);

	// handshake: items are taken only at the idle step of the program
	assign data_stall = !ctl.in_rdy;
	assign accept     = data_valid && ctl.in_rdy;
	assign out_free   = !result_valid_q || !result_stall;
	assign out_load   = ctl.out_ld && out_free;

	assign flags.accept     = accept;
	assign flags.need_sched = need_q;
	assign flags.out_free   = out_free;
	assign flags.n_last     = (n_q == IDX_W'(TABLE_SIZE - 1));

	// key byte for the current schedule step, cycling over KEY_BYTES
	assign key_flat = {key_q[3], key_q[2], key_q[1], key_q[0]};
	assign key_sel  = KEY_SEL_W'(kidx_q);
	assign key_byte = key_flat[key_sel*8 +: 8];

	// memory read address
	always_comb begin
		mem_re    = 1'b1;
		mem_raddr = '0;
		case (ctl.rd_sel)
			RD_I_NEXT: mem_raddr = i_q + 1'b1;
			RD_J:      mem_raddr = j_q;
			RD_AB:     mem_raddr = a_q + b_q;
			RD_N:      mem_raddr = n_q;
			default:   mem_re    = 1'b0;
		endcase
	end

	// memory write port
	always_comb begin
		mem_we    = 1'b1;
		mem_waddr = '0;
		mem_wdata = '0;
		case (ctl.wr_sel)
			WR_N_IDX: begin
				mem_waddr = n_q;
				mem_wdata = n_q;
			end
			WR_N_RD: begin
				mem_waddr = n_q;
				mem_wdata = rd_q;
			end
			WR_I_RD: begin
				mem_waddr = i_q;
				mem_wdata = rd_q;
			end
			WR_J_A: begin
				mem_waddr = j_q;
				mem_wdata = a_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			perm_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= perm_mem[mem_raddr];
	end

	// key words, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++)
				key_q[k] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_WORD_0: key_q[0] <= cfg_data;
				CFG_KEY_WORD_1: key_q[1] <= cfg_data;
				CFG_KEY_WORD_2: key_q[2] <= cfg_data;
				CFG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// indices and schedule control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
			kidx_q <= '0;
			need_q <= 1'b1;
		end else begin
			if (ctl.i_inc)
				i_q <= i_q + 1'b1;
			// j steps by the fetched entry, plus the key byte in the schedule
			if (ctl.a_ld)
				j_q <= j_q + rd_q + (ctl.key_add ? key_byte : 8'd0);
			if (ctl.n_inc)
				n_q <= n_q + 1'b1;
			if (ctl.k_inc)
				kidx_q <= (kidx_q == KIDX_W'(KEY_BYTES - 1)) ? '0 : kidx_q + 1'b1;
			// schedule start: j and key position restart
			if (ctl.sch_init) begin
				j_q    <= '0;
				kidx_q <= '0;
			end
			// schedule end: both indices restart for the message
			if (ctl.sch_end) begin
				i_q    <= '0;
				j_q    <= '0;
				need_q <= 1'b0;
			end
			// a delivered last byte arms the schedule for the next message
			if (out_load && last_q)
				need_q <= 1'b1;
		end
	end

	// payload holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= data_byte;
			last_q <= last_byte;
		end
		if (ctl.a_ld)
			a_q <= rd_q;
		if (ctl.b_ld)
			b_q <= rd_q;
		if (out_load) begin
			out_byte_q <= (rd_q == data_q) ? data_q : ks_xor;
			out_last_q <= last_q;
		end
	end

	assign ks_xor = rd_q ^ data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (out_load)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;

	// the block is busy right after it takes an item
	`RC4SC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, data_stall,
		"item accepted while previous one still in work")
	// a pending schedule is entered straight from the accepting step
	`RC4SC_ASSERT_NEXT(a_sched_entry, clk, arst_n, accept && need_q, step == STEP_INIT,
		"schedule skipped for first byte of message")
	// the schedule counter always returns to zero between passes
	`RC4SC_ASSERT_NOW(a_n_idle_zero, clk, arst_n, step == STEP_IDLE, n_q == '0,
		"schedule counter not at zero while idle")

endmodule

// File: tb/rc4_stream_cipher_nonzero_unit_tb.sv
module rc4_stream_cipher_nonzero_unit_tb;
	import rc4sc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no item moving on either channel before the run is called hung
	localparam int QUIET_LIMIT = 20000;
	localparam int LONG_MSG    = 300;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} plain_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} cipher_item_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             data_valid = 1'b0;
	logic             data_stall;
	logic [7:0]       data_byte = '0;
	logic             last_byte = 1'b0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [7:0]       out_byte;
	logic             out_last;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = CFG_KEY_WORD_0;
	logic [KEY_W-1:0] cfg_data = '0;

	// bytes waiting to go out, and the cipher bytes owed by the block
	plain_item_t  bytes_to_send[$];
	cipher_item_t cipher_due[$];
	plain_item_t  now_sending = '0;

	// key as written to the block, all four words packed, byte 0 lowest
	logic [KEY_WORDS*KEY_W-1:0] key_bits = '0;

	// predictor state: key latched by the last schedule and position in the message
	logic [KEY_WORDS*KEY_W-1:0] active_key = '0;
	int                         stream_pos = 0;
	bit                         rekey_due = 1'b1;

	// same bookkeeping on the stimulus side, used to aim bytes at the keystream
	logic [KEY_WORDS*KEY_W-1:0] plan_key = '0;
	int                         plan_pos = 0;
	bit                         plan_due = 1'b1;
	int                         msg_left = 0;

	bit presenting = 1'b0;
	bit item_taken = 1'b0;
	bit quiet_mode = 1'b0;
	bit stall_on = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	int mismatches = 0;
	int n_checked = 0;
	int n_sched = 0;
	int n_pass = 0;
	int n_key_writes = 0;
	int longest_msg = 0;

	rc4_stream_cipher_nonzero_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// keystream byte number pos of a message: fresh key schedule, then pos+1 generator steps
	function automatic logic [7:0] rc4_keystream(input logic [KEY_WORDS*KEY_W-1:0] key,
			input int pos);
		logic [7:0] perm [TABLE_SIZE];
		logic [7:0] ii, jj, a, b, sum;
		int n;
		for (n = 0; n < TABLE_SIZE; n++)
			perm[n] = n[7:0];
		jj = '0;
		for (n = 0; n < TABLE_SIZE; n++) begin
			a = perm[n];
			jj = jj + a + key[(n % KEY_BYTES) * 8 +: 8];
			perm[n] = perm[jj];
			perm[jj] = a;
		end
		ii = '0;
		jj = '0;
		a = '0;
		b = '0;
		for (n = 0; n <= pos; n++) begin
			ii = ii + 8'd1;
			a = perm[ii];
			jj = jj + a;
			b = perm[jj];
			perm[ii] = b;
			perm[jj] = a;
		end
		sum = a + b;
		return perm[sum];
	endfunction

	// expected cipher byte for one accepted item
	function automatic cipher_item_t encipher_byte(input logic [7:0] data, input logic last);
		cipher_item_t res;
		logic [7:0] ks;
		if (rekey_due) begin
			active_key = key_bits;
			stream_pos = 0;
			rekey_due = 1'b0;
			n_sched++;
		end
		ks = rc4_keystream(active_key, stream_pos);
		stream_pos++;
		if (stream_pos > longest_msg)
			longest_msg = stream_pos;
		// keystream equal to the byte: pass through instead of a zero
		if (ks == data) begin
			res.value = data;
			n_pass++;
		end else begin
			res.value = ks ^ data;
		end
		res.last = last;
		if (last)
			rekey_due = 1'b1;
		return res;
	endfunction

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic int pick_msg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(9, 40);
		else
			return $urandom_range(41, 100);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// queue one byte; aim_ks replaces the data with the keystream byte it will meet
	task automatic push_byte(input logic [7:0] data, input logic last, input bit aim_ks);
		plain_item_t it;
		if (plan_due) begin
			plan_key = key_bits;
			plan_pos = 0;
			plan_due = 1'b0;
		end
		it.value = aim_ks ? rc4_keystream(plan_key, plan_pos) : data;
		it.last = last;
		bytes_to_send.push_back(it);
		plan_pos++;
		if (last)
			plan_due = 1'b1;
	endtask

	task automatic write_key_word(input logic [1:0] sel, input logic [KEY_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		key_bits[sel * KEY_W +: KEY_W] = value;
		n_key_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until every owed cipher byte is back
	task automatic wait_drained();
		while (bytes_to_send.size() != 0 || presenting || cipher_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int count, input bit with_long);
		int k;
		logic [7:0] d;
		int r;
		bit want_long;
		want_long = with_long;
		for (k = 0; k < count; k++) begin
			if (msg_left == 0) begin
				msg_left = want_long ? LONG_MSG : pick_msg_len();
				want_long = 1'b0;
			end
			r = $urandom_range(0, 15);
			if (r == 0)
				d = 8'h00;
			else if (r == 1)
				d = 8'hff;
			else
				d = 8'($urandom_range(0, 255));
			push_byte(d, msg_left == 1, $urandom_range(0, 7) == 0);
			msg_left--;
		end
	endtask

	// sender and receiver side, both moving on the falling edge
	always @(negedge clk) begin
		if (item_taken) begin
			item_taken = 1'b0;
			presenting = 1'b0;
			send_gap = quiet_mode ? 0 : pick_idle_len();
		end
		if (!presenting) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (bytes_to_send.size() != 0) begin
				now_sending = bytes_to_send.pop_front();
				presenting = 1'b1;
			end
		end
		data_valid <= presenting;
		data_byte <= now_sending.value;
		last_byte <= now_sending.last;

		// receiver picks runs of stall or no stall at random
		if (stall_left == 0) begin
			stall_on = !quiet_mode && ($urandom_range(0, 2) == 0);
			stall_left = stall_on ? pick_idle_len() + 1 : $urandom_range(1, 24);
		end
		result_stall <= stall_on;
		stall_left--;
	end

	// both handshakes sampled on the rising edge, plus the hang watchdog
	always @(posedge clk) begin
		cipher_item_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				n_checked++;
				if (cipher_due.size() == 0) begin
					report_mismatch($sformatf("unexpected item out_byte %02h out_last %0b",
						out_byte, out_last));
				end else begin
					want = cipher_due.pop_front();
					if (out_byte !== want.value || out_last !== want.last)
						report_mismatch($sformatf(
							"item %0d: out_byte %02h out_last %0b, expected %02h %0b",
							n_checked, out_byte, out_last, want.value, want.last));
				end
			end
			if (data_valid && !data_stall) begin
				moved = 1'b1;
				item_taken = 1'b1;
				cipher_due.push_back(encipher_byte(data_byte, last_byte));
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int p;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset key of all zeros: one-byte messages back to back, byte extremes,
		// bytes aimed at the keystream so they pass through
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hff, 1'b1, 1'b0);
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h55, 1'b0, 1'b0);
		push_byte(8'haa, 1'b0, 1'b0);
		push_byte(8'h80, 1'b1, 1'b0);
		wait_drained();

		// all-ones key in every word; this message is left open
		write_key_word(CFG_KEY_WORD_0, '1);
		write_key_word(CFG_KEY_WORD_1, '1);
		write_key_word(CFG_KEY_WORD_2, '1);
		write_key_word(CFG_KEY_WORD_3, '1);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b0);
		wait_drained();

		// key change mid-message: the open message keeps the old key,
		// the next one picks up the new key
		write_key_word(CFG_KEY_WORD_0, {$urandom, $urandom});
		write_key_word(CFG_KEY_WORD_1, 64'h0123_4567_89ab_cdef);
		push_byte(8'h7f, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'hfe, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h00, 1'b1, 1'b0);
		wait_drained();

		// random phases; phase 2 runs without any idling, phase 5 carries a
		// message long enough to wrap the generator index
		for (p = 0; p < 8; p++) begin
			quiet_mode = (p == 2);
			if (p == 0 || $urandom_range(0, 1))
				write_key_word(CFG_KEY_WORD_0, pick_key());
			if (p == 0 || $urandom_range(0, 1))
				write_key_word(CFG_KEY_WORD_1, pick_key());
			if (p == 0 || $urandom_range(0, 3) == 0)
				write_key_word(CFG_KEY_WORD_2, pick_key());
			if (p == 0 || $urandom_range(0, 3) == 0)
				write_key_word(CFG_KEY_WORD_3, pick_key());
			run_random_phase((p == 5) ? LONG_MSG : 75, p == 5);
			wait_drained();
		end
		quiet_mode = 1'b0;

		// let any stray item show up
		repeat (40) @(negedge clk);
		if (cipher_due.size() != 0)
			report_mismatch($sformatf("%0d expected items never came out",
				cipher_due.size()));

		$display("covered %0d bytes over %0d key schedules, longest message %0d bytes",
			n_checked, n_sched, longest_msg);
		$display("%0d bytes passed through on a keystream hit, %0d key register writes",
			n_pass, n_key_writes);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
